// ===== design/tcw_pkg.sv =====
package tcw_pkg;

  // Datapath widths
  localparam int unsigned DataW  = 32;
  localparam int unsigned LimitW = 30;
  localparam int unsigned SegW   = 16;
  localparam int unsigned ShiftW = 4;
  localparam int unsigned FlightW = 31;

  // Operation codes of an input item
  typedef enum logic [2:0] {
    OP_HANDSHAKE = 3'd0,
    OP_ACK_OPEN  = 3'd1,
    OP_ACK_CLOSE = 3'd2,
    OP_TIMEOUT   = 3'd3,
    OP_SEND_CHK  = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [2:0] {
    STS_DONE      = 3'd0,
    STS_PEER_FULL = 3'd1,
    STS_CWND_FULL = 3'd2,
    STS_ZERO_LEN  = 3'd3,
    STS_IGNORED   = 3'd4
  } status_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MSS_CAP     = 2'd0,
    CFG_LOSS_WINDOW = 2'd1,
    CFG_INIT_THRESH = 2'd2
  } cfg_idx_e;

  // Reset values of the configuration registers
  localparam logic [SegW-1:0]  MssCapReset     = 16'd1460;
  localparam logic [SegW-1:0]  LossWindowReset = 16'd1460;
  localparam logic [DataW-1:0] InitThreshReset = 32'd65535;

  // Segment size bands for the initial window
  localparam logic [SegW-1:0]   SegLarge  = 16'd2190;
  localparam logic [SegW-1:0]   SegMedium = 16'd1095;
  localparam logic [ShiftW-1:0] MaxShift  = 4'd14;

endpackage

// ===== design/tcw_divider.sv =====
module tcw_divider
  import tcw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             done_o,
  output logic [DataW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DataW);
  localparam logic [CntW-1:0] LastStep = CntW'(DataW - 1);

  logic             running_q;
  logic             done_q;
  logic [CntW-1:0]  cnt_q;
  logic [DataW-1:0] rem_q;
  logic [DataW-1:0] quo_q;
  logic [DataW-1:0] div_q;

  logic [DataW:0]   shifted;
  logic [DataW:0]   trial;
  logic             fits;

  // One restoring step: bring down the next dividend bit and try a subtract
  always_comb begin
    shifted = {rem_q, quo_q[DataW-1]};
    trial   = shifted - {1'b0, div_q};
    fits    = !trial[DataW];
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        running_q <= 1'b1;
        cnt_q     <= '0;
      end else if (running_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          running_q <= 1'b0;
          done_q    <= 1'b1;
          cnt_q     <= '0;
        end
      end
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (running_q) begin
      rem_q <= fits ? trial[DataW-1:0] : shifted[DataW-1:0];
      quo_q <= {quo_q[DataW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(running_q))
    else $error("divider finished without running");

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> running_q)
    else $error("divider did not start");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> cnt_q == '0)
    else $error("divider step count not cleared when idle");

endmodule

// ===== design/tcp_congestion_window.sv =====
// Congestion and window controller for the send side of one TCP connection.
// Input channel: in_valid_i / in_stall_o carry one operation with its fields
// (handshake, ack, ack while closing, retransmit timeout, send check).
// Output channel: out_valid_o / out_stall_i return exactly one result per
// operation: status, cwnd, ssthresh, newly acked bytes and the scaled peer
// window, all taken after the operation.
// Configuration: cfg_valid_i / cfg_ready_o write mss_cap (0), loss_window (1)
// and initial_threshold (2); write only while the block is idle.
// An ack in congestion avoidance runs a restoring divider, one quotient bit
// per cycle over its 32 steps (segment_size squared over cwnd); other
// operations go from the execute state straight to the result state.
// One item is worked on at a time; a new item is not accepted until the
// last one's result has been loaded into the output register.
// A result waits in the output register while the receiver stalls; the next
// item may be accepted meanwhile, but its result is held back until the
// waiting one is transferred.
// Reset clears the connection state to zero and loads the register defaults.
module tcp_congestion_window
  import tcw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i,
  // Input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         operation_i,
  input  logic [DataW-1:0]   ack_number_i,
  input  logic [DataW-1:0]   send_next_i,
  input  logic [SegW-1:0]    peer_window_i,
  input  logic [SegW-1:0]    peer_mss_i,
  input  logic [ShiftW-1:0]  peer_shift_i,
  input  logic [FlightW-1:0] flight_bytes_i,
  input  logic [SegW-1:0]    send_length_i,
  // Output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [DataW-1:0]   window_now_o,
  output logic [DataW-1:0]   threshold_now_o,
  output logic [DataW-1:0]   acked_bytes_o,
  output logic [LimitW-1:0]  send_limit_now_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0] state_q, state_d;

  // Configuration registers
  logic [SegW-1:0]  mss_cap_q;
  logic [SegW-1:0]  loss_window_q;
  logic [DataW-1:0] init_thresh_q;

  // Connection state
  logic [DataW-1:0]  cwnd_q, cwnd_d;
  logic [DataW-1:0]  thresh_q, thresh_d;
  logic [DataW-1:0]  last_ack_q, last_ack_d;
  logic [LimitW-1:0] limit_q, limit_d;
  logic [SegW-1:0]   seg_q, seg_d;
  logic [ShiftW-1:0] scale_q, scale_d;

  // Captured input item
  logic [2:0]         op_q;
  logic [DataW-1:0]   ack_q;
  logic [DataW-1:0]   snd_q;
  logic [SegW-1:0]    pwin_q;
  logic [SegW-1:0]    pmss_q;
  logic [ShiftW-1:0]  pshift_q;
  logic [FlightW-1:0] flight_q;
  logic [SegW-1:0]    slen_q;

  // Per-item result held until the output register is free
  status_e          sts_q, sts_d;
  logic [DataW-1:0] acked_q, acked_d;

  // Output register
  logic              out_valid_q;
  logic [2:0]        out_status_q;
  logic [DataW-1:0]  out_window_q;
  logic [DataW-1:0]  out_thresh_q;
  logic [DataW-1:0]  out_acked_q;
  logic [LimitW-1:0] out_limit_q;

  // Divider hookup
  logic             div_start;
  logic             div_done;
  logic [DataW-1:0] div_quot;
  logic [DataW-1:0] seg_sq;

  logic in_xfer;
  logic out_free;
  logic out_load;

  // Execute-stage helpers
  logic [SegW-1:0]    hs_seg;
  logic [SegW+1:0]    hs_seg_x;
  logic [ShiftW-1:0]  hs_shift;
  logic [DataW+13:0]  ack_shifted;
  logic               ack_ok;
  logic [DataW-1:0]   ack_diff;
  logic [SegW-1:0]    ss_add;
  logic [DataW:0]     ss_sum;
  logic [DataW:0]     seg_sum;
  logic [DataW:0]     ca_sum;
  logic [DataW-1:0]   half_flight;
  logic [DataW-1:0]   loss_floor;
  logic [DataW:0]     need;

  assign in_xfer     = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == ST_RESULT) && out_free;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mss_cap_q     <= MssCapReset;
      loss_window_q <= LossWindowReset;
      init_thresh_q <= InitThreshReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MSS_CAP:     mss_cap_q     <= cfg_data_i[SegW-1:0];
        CFG_LOSS_WINDOW: loss_window_q <= cfg_data_i[SegW-1:0];
        CFG_INIT_THRESH: init_thresh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture the input item on transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q     <= operation_i;
      ack_q    <= ack_number_i;
      snd_q    <= send_next_i;
      pwin_q   <= peer_window_i;
      pmss_q   <= peer_mss_i;
      pshift_q <= peer_shift_i;
      flight_q <= flight_bytes_i;
      slen_q   <= send_length_i;
    end
  end

  // Operand terms used by the execute stage
  always_comb begin
    hs_seg      = (pmss_q > mss_cap_q) ? mss_cap_q : pmss_q;
    hs_shift    = (pshift_q > MaxShift) ? MaxShift : pshift_q;
    ack_shifted = {{(DataW-2){1'b0}}, pwin_q} << scale_q;
    if (last_ack_q <= snd_q) begin
      ack_ok = (last_ack_q < ack_q) && (ack_q <= snd_q);
    end else begin
      ack_ok = (last_ack_q < ack_q) || (ack_q <= snd_q);
    end
    ack_diff    = ack_q - last_ack_q;
    ss_add      = (ack_diff >= {16'd0, seg_q}) ? seg_q : ack_diff[SegW-1:0];
    ss_sum      = {1'b0, cwnd_q} + {17'd0, ss_add};
    seg_sum     = {1'b0, cwnd_q} + {17'd0, seg_q};
    half_flight = {2'b0, flight_q[FlightW-1:1]};
    loss_floor  = {15'd0, loss_window_q, 1'b0};
    need        = {2'b0, flight_q} + {17'd0, slen_q};
    // Initial window: 2, 3 or 4 segments by size band
    if (hs_seg > SegLarge) begin
      hs_seg_x = {1'b0, hs_seg, 1'b0};
    end else if (hs_seg > SegMedium) begin
      hs_seg_x = {2'b0, hs_seg} + {1'b0, hs_seg, 1'b0};
    end else begin
      hs_seg_x = {hs_seg, 2'b0};
    end
  end

  // Saturating add of the divider's quotient
  assign ca_sum = {1'b0, cwnd_q} + {1'b0, div_quot};

  // Execute one operation and sequence the item
  always_comb begin
    state_d    = state_q;
    cwnd_d     = cwnd_q;
    thresh_d   = thresh_q;
    last_ack_d = last_ack_q;
    limit_d    = limit_q;
    seg_d      = seg_q;
    scale_d    = scale_q;
    sts_d      = sts_q;
    acked_d    = acked_q;
    div_start  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        sts_d   = STS_DONE;
        acked_d = '0;
        state_d = ST_RESULT;
        case (op_e'(op_q))
          OP_HANDSHAKE: begin
            if (pmss_q != '0) begin
              seg_d = hs_seg;
              if (hs_seg != '0) begin
                cwnd_d = {14'd0, hs_seg_x};
              end
            end
            last_ack_d = ack_q;
            limit_d    = {14'd0, pwin_q};
            scale_d    = hs_shift;
            thresh_d   = init_thresh_q;
          end
          OP_ACK_OPEN, OP_ACK_CLOSE: begin
            limit_d = ack_shifted[LimitW-1:0];
            if (ack_ok) begin
              acked_d    = ack_diff;
              last_ack_d = ack_q;
              if (op_q == OP_ACK_OPEN) begin
                if (cwnd_q < thresh_q) begin
                  cwnd_d = ss_sum[DataW] ? '1 : ss_sum[DataW-1:0];
                end else if (cwnd_q == '0) begin
                  cwnd_d = seg_sum[DataW] ? '1 : seg_sum[DataW-1:0];
                end else begin
                  div_start = 1'b1;
                  state_d   = ST_DIV;
                end
              end
            end else begin
              sts_d = STS_IGNORED;
            end
          end
          OP_TIMEOUT: begin
            thresh_d = (half_flight > loss_floor) ? half_flight : loss_floor;
            cwnd_d   = {16'd0, loss_window_q};
          end
          OP_SEND_CHK: begin
            if (slen_q == '0) begin
              sts_d = STS_ZERO_LEN;
            end else if ({2'b0, limit_q} < cwnd_q) begin
              if ({3'b0, limit_q} < need) begin
                sts_d = STS_PEER_FULL;
              end
            end else if ({1'b0, cwnd_q} < need) begin
              sts_d = STS_CWND_FULL;
            end
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          cwnd_d  = ca_sum[DataW] ? '1 : ca_sum[DataW-1:0];
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer and connection state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cwnd_q     <= '0;
      thresh_q   <= '0;
      last_ack_q <= '0;
      limit_q    <= '0;
      seg_q      <= '0;
      scale_q    <= '0;
    end else begin
      state_q    <= state_d;
      cwnd_q     <= cwnd_d;
      thresh_q   <= thresh_d;
      last_ack_q <= last_ack_d;
      limit_q    <= limit_d;
      seg_q      <= seg_d;
      scale_q    <= scale_d;
    end
  end

  // Held status and acked count, plus the registered square for the divider
  always_ff @(posedge clk_i) begin
    sts_q   <= sts_d;
    acked_q <= acked_d;
    seg_sq  <= {16'd0, seg_q} * {16'd0, seg_q};
  end

  tcw_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (seg_sq),
    .divisor_i  (cwnd_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Output register: load a finished result, drop it on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= sts_q;
      out_window_q <= cwnd_q;
      out_thresh_q <= thresh_q;
      out_acked_q  <= acked_q;
      out_limit_q  <= limit_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign window_now_o     = out_window_q;
  assign threshold_now_o  = out_thresh_q;
  assign acked_bytes_o    = out_acked_q;
  assign send_limit_now_o = out_limit_q;

  a_exec_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == ST_EXEC)
    else $error("accepted item not executed");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider result outside divide state");

  a_ignored_no_acked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STS_IGNORED |-> acked_bytes_o == '0)
    else $error("ignored ack reports acked bytes");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> !$past(out_load))
    else $error("output register overwritten while stalled");

endmodule
